// ===== src/vp_pkg.sv =====
// ----------------------------------------------------------------------------
// vp_pkg: shared definitions for the vector projection block
// Widths, pipeline depth and the divider state word.
// ----------------------------------------------------------------------------
package vp_pkg;

  // Q8.8 component width.
  localparam int QW = 16;
  // Quotient bits the divider produces. One bit more than a component so
  // that negative full scale is reachable before clamping.
  localparam int QBITS = QW + 1;
  // Front stages: products, sums, scaled product, divider setup.
  localparam int NFRONT = 4;
  // Total pipeline stages ahead of the output register.
  localparam int NSTG = NFRONT + QBITS;
  // Number of vector components, one lane each.
  localparam int NLANE = 3;

  localparam int PW   = 2 * QW;          // product of two components
  localparam int NNW  = 2 * QW;          // u.u, at most 3 * 2^30
  localparam int DOTW = 2 * QW + 2;      // a.u with sign and carry room
  localparam int SPW  = DOTW + QW;       // (a.u) * u_i
  localparam int MAGW = 3 * QW;          // |(a.u) * u_i|, at most 3 * 2^45

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef logic signed [QW-1:0] comp_t;

  // State of one restoring division in flight.
  typedef struct packed {
    logic [NNW-1:0]   rem;   // partial remainder
    logic [QBITS-1:0] lq;    // dividend low bits shifting out, quotient in
    logic [NNW-1:0]   nn;    // divisor u.u
    logic             neg;   // quotient sign
    logic             ovf;   // quotient magnitude exceeds QBITS bits
  } div_t;

endpackage

// ===== src/vp_div_step.sv =====
// ----------------------------------------------------------------------------
// vp_div_step: one registered restoring division step
// Shifts one dividend bit into the remainder and retires one quotient bit.
// ----------------------------------------------------------------------------
module vp_div_step (
  input  logic          clk,
  input  logic          en,
  input  vp_pkg::div_t  d_i,
  output vp_pkg::div_t  d_r
);
  import vp_pkg::*;

  logic [NNW:0]   trial;
  logic           ge;
  logic [NNW:0]   diff;
  div_t           d_nxt;

  always_comb begin
    trial = {d_i.rem, d_i.lq[QBITS-1]};
    ge    = (trial >= {1'b0, d_i.nn});
    diff  = trial - {1'b0, d_i.nn};
    d_nxt     = d_i;
    d_nxt.rem = ge ? diff[NNW-1:0] : trial[NNW-1:0];
    d_nxt.lq  = {d_i.lq[QBITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== src/vp_lane.sv =====
// ----------------------------------------------------------------------------
// vp_lane: one component lane of the projection pipeline
// Forms the lane's products, then (a.u) * u_i / (u.u) with clamping.
// ----------------------------------------------------------------------------
module vp_lane (
  input  logic                          clk,
  input  logic [vp_pkg::NSTG-1:0]       en,
  input  vp_pkg::comp_t                 axis,
  input  vp_pkg::comp_t                 vec,
  output logic signed [vp_pkg::PW-1:0]  prod_au,
  output logic [vp_pkg::PW-1:0]         prod_uu,
  input  logic signed [vp_pkg::DOTW-1:0] dot,
  input  logic [vp_pkg::NNW-1:0]        nn,
  output vp_pkg::comp_t                 proj,
  output logic                          sat
);
  import vp_pkg::*;

  logic signed [PW-1:0]   prod_au_r;
  logic [PW-1:0]          prod_uu_r;
  logic signed [PW-1:0]   uu_full;
  comp_t                  u0_r, u1_r;
  logic signed [SPW-1:0]  sp_r;
  logic [NNW-1:0]         nn2_r;
  logic [SPW-1:0]         sp_abs;
  logic [MAGW-1:0]        mag;
  div_t                   setup_nxt, setup_r;
  div_t                   chain [QBITS+1];
  logic [QBITS-1:0]       q;
  div_t                   last;

  // Stage 0: component products.
  assign uu_full = axis * axis;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_au_r <= vec * axis;
      prod_uu_r <= uu_full;
      u0_r      <= axis;
    end
  end
  assign prod_au = prod_au_r;
  assign prod_uu = prod_uu_r;

  // Stage 1: the sums are formed outside; the axis component waits here.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      u1_r <= u0_r;
    end
  end

  // Stage 2: scale the dot product by this lane's axis component.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sp_r  <= dot * u1_r;
      nn2_r <= nn;
    end
  end

  // Stage 3: split sign and magnitude, check that the quotient fits.
  always_comb begin
    sp_abs = sp_r[SPW-1] ? (~sp_r + 1'b1) : sp_r;
    mag    = sp_abs[MAGW-1:0];
    setup_nxt.rem = {1'b0, mag[MAGW-1:QBITS]};
    setup_nxt.lq  = mag[QBITS-1:0];
    setup_nxt.nn  = nn2_r;
    setup_nxt.neg = sp_r[SPW-1];
    setup_nxt.ovf = ({1'b0, mag[MAGW-1:QBITS]} >= nn2_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      setup_r <= setup_nxt;
    end
  end

  // Stages 4 and on: one quotient bit per stage.
  assign chain[0] = setup_r;
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    vp_div_step u_step (
      .clk (clk),
      .en  (en[NFRONT+k]),
      .d_i (chain[k]),
      .d_r (chain[k+1])
    );
  end

  // Apply the sign and clamp to the Q8.8 range.
  assign last = chain[QBITS];
  assign q    = last.lq;

  always_comb begin
    if (last.ovf) begin
      sat  = 1'b1;
      proj = last.neg ? Q_MIN : Q_MAX;
    end else if (last.neg) begin
      sat  = (q > {1'b0, Q_MIN});
      proj = sat ? Q_MIN : comp_t'(~q[QW-1:0] + 1'b1);
    end else begin
      sat  = (q > {1'b0, Q_MAX});
      proj = sat ? Q_MAX : comp_t'(q[QW-1:0]);
    end
  end

endmodule

// ===== src/vector_projection.sv =====
// ----------------------------------------------------------------------------
// vector_projection: projection of a vector onto an axis, Q8.8
// Returns ((a.u) / (u.u)) * u per request, fully pipelined in three lanes.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while in_ready is high and returns
// one result per request, in order, from the registered outputs.
// Throughput is set by the pipeline: three lanes, one per component, each
// with a multiplier stage, a scaled product stage, a setup stage and a
// 17-stage restoring divider that retires one quotient bit per cycle; the
// lane products are merged into u.u and a.u after the first stage, and the
// lanes' clamped quotients and flags are merged in the output register.
// Stalls collapse bubbles: a stage loads whenever it is empty or the stage
// after it moves, so requests keep entering while a finished result waits
// until the pipeline is actually full. Each component is truncated toward
// zero and clamped to [-32768, 32767]; saturated reports any clamp. An axis
// of all zeros yields a zero vector with zero_axis set and saturated clear.
// ----------------------------------------------------------------------------
module vector_projection (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_axis_x,
  input  logic signed [15:0]   in_axis_y,
  input  logic signed [15:0]   in_axis_z,
  input  logic signed [15:0]   in_vec_x,
  input  logic signed [15:0]   in_vec_y,
  input  logic signed [15:0]   in_vec_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_proj_x,
  output logic signed [15:0]   out_proj_y,
  output logic signed [15:0]   out_proj_z,
  output logic                 out_zero_axis,
  output logic                 out_saturated
);
  import vp_pkg::*;

  // Occupancy of each stage and the bubble-collapsing ready chain.
  logic [NSTG-1:0]        v_r;
  logic [NSTG:0]          rdy;
  logic                   out_valid_r;

  // Per-lane views of the request and lane results.
  comp_t                  axis_w [NLANE];
  comp_t                  vec_w  [NLANE];
  logic signed [PW-1:0]   au_w   [NLANE];
  logic [PW-1:0]          uu_w   [NLANE];
  comp_t                  proj_w [NLANE];
  logic [NLANE-1:0]       sat_w;

  // Merged sums, stage 1.
  logic signed [DOTW-1:0] dot_r;
  logic [NNW-1:0]         nn_r;
  logic [NNW+1:0]         nn_sum;
  logic signed [DOTW-1:0] dot_sum;

  // Zero-axis flag travelling alongside the lanes from stage 1 on.
  logic [NSTG-1:1]        zero_r;

  comp_t                  proj_x_r, proj_y_r, proj_z_r;
  logic                   zero_axis_r, saturated_r;

  assign axis_w[0] = in_axis_x;
  assign axis_w[1] = in_axis_y;
  assign axis_w[2] = in_axis_z;
  assign vec_w[0]  = in_vec_x;
  assign vec_w[1]  = in_vec_y;
  assign vec_w[2]  = in_vec_z;

  // A stage may load when it holds nothing or when its contents move on.
  always_comb begin
    rdy[NSTG] = !out_valid_r || out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy[NSTG]) begin
        out_valid_r <= v_r[NSTG-1];
      end
    end
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    vp_lane u_lane (
      .clk     (clk),
      .en      (rdy[NSTG-1:0]),
      .axis    (axis_w[i]),
      .vec     (vec_w[i]),
      .prod_au (au_w[i]),
      .prod_uu (uu_w[i]),
      .dot     (dot_r),
      .nn      (nn_r),
      .proj    (proj_w[i]),
      .sat     (sat_w[i])
    );
  end

  // Merge the lane products into a.u and u.u. The sum of squares never
  // exceeds 3 * 2^30, so it fits the divisor width exactly.
  assign nn_sum  = {2'b00, uu_w[0]} + {2'b00, uu_w[1]} + {2'b00, uu_w[2]};
  assign dot_sum = DOTW'(au_w[0]) + DOTW'(au_w[1]) + DOTW'(au_w[2]);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      nn_r      <= nn_sum[NNW-1:0];
      dot_r     <= dot_sum;
      zero_r[1] <= (nn_sum == '0);
    end
    for (int k = 2; k < NSTG; k++) begin
      if (rdy[k]) begin
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  // Output register: a zero axis overrides whatever the divider produced.
  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      if (zero_r[NSTG-1]) begin
        proj_x_r    <= '0;
        proj_y_r    <= '0;
        proj_z_r    <= '0;
        zero_axis_r <= 1'b1;
        saturated_r <= 1'b0;
      end else begin
        proj_x_r    <= proj_w[0];
        proj_y_r    <= proj_w[1];
        proj_z_r    <= proj_w[2];
        zero_axis_r <= 1'b0;
        saturated_r <= |sat_w;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_proj_x    = proj_x_r;
  assign out_proj_y    = proj_y_r;
  assign out_proj_z    = proj_z_r;
  assign out_zero_axis = zero_axis_r;
  assign out_saturated = saturated_r;

  // A zero axis always comes out as a clean zero vector.
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_axis) |->
      (!out_saturated && out_proj_x == '0 && out_proj_y == '0 && out_proj_z == '0))
    else $error("zero axis result is not a clean zero vector");

  // A result that is not taken is neither dropped nor replaced.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_proj_x) &&
      $stable(out_saturated) && $stable(out_zero_axis)))
    else $error("stalled result changed");

  // An empty first stage must always take a new request.
  a_front_open: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("input stalled with an empty first stage");

  // Bubbles are squeezed out: with any empty stage the input is not blocked
  // by the output side alone.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> (&v_r && out_valid && !out_ready))
    else $error("input stalled while the pipeline had room");

endmodule
